// File: src/m2vchp_pkg.sv
// Package for the MPEG-2 video chunk header parser.
// Holds the input and result word types, start code constants and the result formatter.
// Depends on nothing; every module of the block imports it.
package m2vchp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [1:0]  chunk_kind;
    logic [23:0] chunk_length;
    logic [11:0] horizontal_size;
    logic [11:0] vertical_size;
    logic [3:0]  aspect_code;
    logic [3:0]  rate_code;
    logic        progressive_seq;
    logic [23:0] gop_time;
    logic [9:0]  temporal_ref;
    logic [2:0]  coding_type;
    logic [1:0]  picture_struct;
    logic [2:0]  picture_flags;
  } out_t;

  typedef enum logic [1:0] {
    KIND_SEQ = 2'd0,
    KIND_GOP = 2'd1,
    KIND_PIC = 2'd2
  } kind_t;

  // Offset within an extension of the next byte; idle when no extension is open.
  typedef enum logic [3:0] {
    EXT_IDLE = 4'd0,
    EXT_ID   = 4'd4,
    EXT_B5   = 4'd5,
    EXT_B6   = 4'd6,
    EXT_B7   = 4'd7,
    EXT_B8   = 4'd8
  } ext_pos_t;

  localparam logic [23:0] START_PREFIX = 24'h000001;
  localparam logic [23:0] RECENT_RESET = 24'hFFFFFF;
  localparam logic [7:0]  SC_SEQ       = 8'hB3;
  localparam logic [7:0]  SC_GOP       = 8'hB8;
  localparam logic [7:0]  SC_PIC       = 8'h00;
  localparam logic [7:0]  SC_EXT       = 8'hB5;
  localparam logic [3:0]  EXT_ID_SEQ   = 4'h1;
  localparam logic [3:0]  EXT_ID_PIC   = 4'h8;
  // Picture extension fields: struct[4:3], tff[2], rff[1], progressive[0].
  localparam logic [4:0]  PIC_DEFAULTS = 5'h1D;
  localparam logic [23:0] LEN_OUT_MAX  = 24'hFFFFFF;
  localparam int unsigned OUTQ_DEPTH   = 3;

  // Builds one result word from kind, length, header bytes 4..7 and extension fields.
  function automatic out_t make_result(input logic [1:0] kind, input logic [23:0] len,
                                       input logic [31:0] hdr, input logic [4:0] pef);
    out_t r;
    r = '0;
    r.chunk_kind   = kind;
    r.chunk_length = len;
    unique case (kind)
      KIND_SEQ: begin
        r.horizontal_size = {hdr[31:24], hdr[23:20]};
        r.vertical_size   = {hdr[19:16], hdr[15:8]};
        r.aspect_code     = hdr[7:4];
        r.rate_code       = hdr[3:0];
        r.progressive_seq = pef[0];
      end
      KIND_GOP: begin
        r.gop_time = {hdr[30:26], hdr[25:20], hdr[18:13], hdr[12:7], hdr[6]};
      end
      KIND_PIC: begin
        r.temporal_ref   = {hdr[31:24], hdr[23:22]};
        r.coding_type    = hdr[21:19];
        r.picture_struct = pef[4:3];
        r.picture_flags  = pef[2:0];
      end
      default: begin
        r.chunk_kind = kind;
      end
    endcase
    return r;
  endfunction

endpackage

// File: src/mpeg2_video_chunk_header_parser_top.sv
// Top level of the MPEG-2 video chunk header parser.
// Instantiates m2vchp_parse and m2vchp_outq; depends on m2vchp_pkg.
//
//   Channel  Ports                          Word                  Direction
//   -------  -----------------------------  --------------------  ---------
//   input    in_valid, in_ready, in_data    in_t  (one byte)      in
//   result   out_valid, out_ready, out_data out_t (one chunk)     out
//
// One byte is taken per clock while in_ready is high. A byte is held in the input
// register and parsed from there; a result word it causes is written into the
// result queue and offered from there on the result channel.
// Reset (rst_n, synchronous, active low) empties the pipeline and puts the parser
// in its search state: bytes are dropped until a sequence, GOP or picture code.
// Results wait in a three-word queue. in_ready drops only when the queue and the
// byte in flight could fill it, which needs two results left untaken; since every
// chunk spans at least four bytes, a stalled result channel does not stop the
// byte stream until results pile up.
module mpeg2_video_chunk_header_parser_top import m2vchp_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Input register: holds the byte accepted at the last edge for parsing.
  logic       in_valid_r;
  in_t        in_word_r;

  logic       res_valid;
  out_t       res_word;
  logic [1:0] fill;

  // Space must remain for the byte in flight and the byte about to be taken.
  assign in_ready = ({1'b0, fill} + {2'b00, in_valid_r}) <= 3'(OUTQ_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
  end

  // The parser never stalls: the queue always has room for its result.
  m2vchp_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid_r),
    .in_word   (in_word_r),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  m2vchp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_word (res_word),
    .fill      (fill),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: src/m2vchp_parse.sv
// Chunking and header parsing state for the MPEG-2 video chunk header parser.
// Processes one registered input word per valid cycle, offering at most one result.
// Depends on m2vchp_pkg.
module m2vchp_parse import m2vchp_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  in_t  in_word,
  output logic res_valid,
  output out_t res_word
);

  localparam int LW = (LENGTH_BITS > 24) ? LENGTH_BITS : 24;
  localparam logic [LENGTH_BITS-1:0] OFF_MAX = {LENGTH_BITS{1'b1}};

  logic [23:0]            recent_r, recent_nxt;
  logic                   in_chunk_r, in_chunk_nxt, in_chunk_upd;
  kind_t                  kind_r, kind_nxt, kind_upd;
  logic [LENGTH_BITS-1:0] off_r, off_nxt, off_upd;
  logic [31:0]            hdr_r, hdr_nxt, hdr_upd;
  ext_pos_t               ext_pos_r, ext_pos_nxt, ext_pos_upd, ext_pos_step;
  logic                   ext_seen_r, ext_seen_nxt, ext_seen_upd, ext_seen_step;
  logic [4:0]             pef_r, pef_nxt, pef_upd, pef_step;

  logic [7:0]             b;
  logic                   eos;
  logic                   wanted;
  logic                   start;
  logic                   emit_code;
  logic                   flush;
  logic                   ext_open;
  kind_t                  new_kind;
  logic [LENGTH_BITS-1:0] len_raw;
  logic [LW-1:0]          len_ext;
  logic [23:0]            len_out;

  assign b      = in_word.data_byte;
  assign eos    = in_word.end_of_stream;
  assign wanted = (recent_r == START_PREFIX) && ((b == SC_SEQ) || (b == SC_GOP) ||
                                                 (b == SC_PIC));
  // A code that overlaps the first four bytes of the open chunk counts as data.
  assign start     = wanted && (!in_chunk_r || (off_r >= LENGTH_BITS'(7)));
  assign emit_code = start && in_chunk_r;

  always_comb begin
    priority if (b == SC_SEQ) begin
      new_kind = KIND_SEQ;
    end else if (b == SC_GOP) begin
      new_kind = KIND_GOP;
    end else begin
      new_kind = KIND_PIC;
    end
  end

  // An extension is searched for only after the fixed header of the chunk.
  always_comb begin
    if (kind_r == KIND_SEQ) begin
      ext_open = off_r >= LENGTH_BITS'(10);
    end else begin
      ext_open = off_r >= LENGTH_BITS'(8);
    end
  end

  // Extension tracker: position within the extension and whether one was taken.
  always_comb begin
    ext_seen_step = ext_seen_r;
    unique case (ext_pos_r)
      EXT_ID: begin
        if (((kind_r == KIND_SEQ) && (b[7:4] == EXT_ID_SEQ)) ||
            ((kind_r == KIND_PIC) && (b[7:4] == EXT_ID_PIC))) begin
          ext_seen_step = 1'b1;
          ext_pos_step  = EXT_B5;
        end else begin
          ext_pos_step = EXT_IDLE;
        end
      end
      EXT_B5: begin
        ext_pos_step = (kind_r == KIND_SEQ) ? EXT_IDLE : EXT_B6;
      end
      EXT_B6: begin
        ext_pos_step = EXT_B7;
      end
      EXT_B7: begin
        ext_pos_step = EXT_B8;
      end
      EXT_B8: begin
        ext_pos_step = EXT_IDLE;
      end
      default: begin
        if (!ext_seen_r && (kind_r != KIND_GOP) && (recent_r == START_PREFIX) &&
            (b == SC_EXT) && ext_open) begin
          ext_pos_step = EXT_ID;
        end else begin
          ext_pos_step = EXT_IDLE;
        end
      end
    endcase
  end

  // Extension fields captured from the bytes after the extension identifier.
  always_comb begin
    pef_step = pef_r;
    unique case (ext_pos_r)
      EXT_B5: begin
        if (kind_r == KIND_SEQ) begin
          pef_step = {4'b0000, b[3]};
        end
      end
      EXT_B6: begin
        pef_step[4:3] = b[1:0];
      end
      EXT_B7: begin
        pef_step[2] = b[7];
        pef_step[1] = b[1];
      end
      EXT_B8: begin
        pef_step[0] = b[7];
      end
      default: begin
        pef_step = pef_r;
      end
    endcase
  end

  // Step of the chunker for the current byte, before the end-of-stream reset.
  always_comb begin
    in_chunk_upd = in_chunk_r;
    kind_upd     = kind_r;
    off_upd      = off_r;
    hdr_upd      = hdr_r;
    ext_pos_upd  = ext_pos_r;
    ext_seen_upd = ext_seen_r;
    pef_upd      = pef_r;
    if (start) begin
      in_chunk_upd = !eos;
      kind_upd     = new_kind;
      off_upd      = LENGTH_BITS'(4);
      hdr_upd      = '0;
      ext_pos_upd  = EXT_IDLE;
      ext_seen_upd = 1'b0;
      pef_upd      = (new_kind == KIND_PIC) ? PIC_DEFAULTS : 5'd0;
    end else if (in_chunk_r) begin
      if ((off_r >= LENGTH_BITS'(4)) && (off_r <= LENGTH_BITS'(7))) begin
        unique case (off_r[1:0])
          2'd0: hdr_upd[31:24] = b;
          2'd1: hdr_upd[23:16] = b;
          2'd2: hdr_upd[15:8]  = b;
          2'd3: hdr_upd[7:0]   = b;
          default: hdr_upd = hdr_r;
        endcase
      end
      ext_pos_upd  = ext_pos_step;
      ext_seen_upd = ext_seen_step;
      pef_upd      = pef_step;
      if (off_r != OFF_MAX) begin
        off_upd = off_r + LENGTH_BITS'(1);
      end
    end
  end

  always_comb begin
    recent_nxt   = {recent_r[15:0], b};
    in_chunk_nxt = in_chunk_upd;
    kind_nxt     = kind_upd;
    off_nxt      = off_upd;
    hdr_nxt      = hdr_upd;
    ext_pos_nxt  = ext_pos_upd;
    ext_seen_nxt = ext_seen_upd;
    pef_nxt      = pef_upd;
    if (eos) begin
      recent_nxt   = RECENT_RESET;
      in_chunk_nxt = 1'b0;
      kind_nxt     = KIND_SEQ;
      off_nxt      = '0;
      hdr_nxt      = '0;
      ext_pos_nxt  = EXT_IDLE;
      ext_seen_nxt = 1'b0;
      pef_nxt      = PIC_DEFAULTS;
    end
  end

  // A new start code closes the chunk with the state as it stood; the final byte
  // closes it with the state that includes that byte.
  assign flush = eos && in_chunk_upd && !emit_code;

  always_comb begin
    if (emit_code) begin
      len_raw = (off_r == OFF_MAX) ? off_r : (off_r - LENGTH_BITS'(3));
    end else begin
      len_raw = off_upd;
    end
    len_ext = LW'(len_raw);
    len_out = (len_ext > LW'(LEN_OUT_MAX)) ? LEN_OUT_MAX : len_ext[23:0];
  end

  assign res_valid = in_valid && (emit_code || flush);
  assign res_word  = emit_code ? make_result(kind_r, len_out, hdr_r, pef_r)
                               : make_result(kind_upd, len_out, hdr_upd, pef_upd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r   <= RECENT_RESET;
      in_chunk_r <= 1'b0;
      kind_r     <= KIND_SEQ;
      off_r      <= '0;
      hdr_r      <= '0;
      ext_pos_r  <= EXT_IDLE;
      ext_seen_r <= 1'b0;
      pef_r      <= PIC_DEFAULTS;
    end else if (in_valid) begin
      recent_r   <= recent_nxt;
      in_chunk_r <= in_chunk_nxt;
      kind_r     <= kind_nxt;
      off_r      <= off_nxt;
      hdr_r      <= hdr_nxt;
      ext_pos_r  <= ext_pos_nxt;
      ext_seen_r <= ext_seen_nxt;
      pef_r      <= pef_nxt;
    end
  end

  a_no_result_outside_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_chunk_r) |-> !res_valid)
    else $error("result produced while no chunk was open");

  a_eos_returns_to_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_word.end_of_stream) |=>
      (!in_chunk_r && (recent_r == RECENT_RESET) && (ext_pos_r == EXT_IDLE)))
    else $error("state not cleared after final byte");

  a_ext_only_in_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (ext_pos_r != EXT_IDLE) |-> (in_chunk_r && (kind_r != KIND_GOP) && ext_seen_r ||
                                 in_chunk_r && (kind_r != KIND_GOP) && ext_pos_r == EXT_ID))
    else $error("extension tracker active outside a sequence or picture chunk");

endmodule

// File: src/m2vchp_outq.sv
// Result queue of the MPEG-2 video chunk header parser: three registered result words.
// Decouples the parser from stalls on the result channel. Depends on m2vchp_pkg.
module m2vchp_outq import m2vchp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  out_t       push_word,
  output logic [1:0] fill,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  out_t       mem [OUTQ_DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != 2'd0;
  assign out_data  = mem[rd_ptr_r];
  assign fill      = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_word;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(OUTQ_DEPTH)) |-> (!push || pop))
    else $error("result queue overflow");

  a_fill_tracks_traffic: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("result queue fill count lost a push");

endmodule

// File: sim/tb_mpeg2_video_chunk_header_parser_top.sv
// Self-checking testbench for mpeg2_video_chunk_header_parser_top: a byte stream is
// driven in, and every chunk word that comes out is checked against a built-in parser.
// Depends on m2vchp_pkg and the block's RTL only.
module tb_mpeg2_video_chunk_header_parser_top;
  import m2vchp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Width of the chunk byte counter, as the block is built here.
  localparam int unsigned LEN_BITS = 24;
  localparam logic [LEN_BITS-1:0] OFFSET_SAT = '1;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  mpeg2_video_chunk_header_parser_top #(
    .LENGTH_BITS(LEN_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bytes waiting to be offered, and chunk words the parser below says must come out.
  in_t  stream_q[$];
  out_t chunk_q[$];
  int   bytes_taken = 0;
  int   fails = 0;

  // ---------------------------------------------------------------------------
  // Parser state, kept in step with every byte the block accepts.
  // ---------------------------------------------------------------------------
  logic [23:0]         last3;      // the three most recent stream bytes
  bit                  open_chunk;
  kind_t               cur_kind;
  logic [LEN_BITS-1:0] offset;     // index of the next byte within the chunk
  logic [31:0]         hdr;        // chunk bytes 4..7, first byte in the top
  ext_pos_t            ext_pos;
  bit                  ext_found;
  logic [4:0]          pic_ext;    // struct[4:3], tff, rff, progressive

  function automatic void parser_clear();
    last3      = RECENT_RESET;
    open_chunk = 1'b0;
    cur_kind   = KIND_SEQ;
    offset     = '0;
    hdr        = '0;
    ext_pos    = EXT_IDLE;
    ext_found  = 1'b0;
    pic_ext    = PIC_DEFAULTS;
  endfunction

  // The word that closes the open chunk, with only the fields of its kind filled in.
  function automatic out_t chunk_word(logic [LEN_BITS-1:0] len);
    out_t w;
    logic [4:0] hours;
    logic [5:0] minutes, seconds, frames;
    w = '0;
    w.chunk_kind   = cur_kind;
    w.chunk_length = len;
    case (cur_kind)
      KIND_SEQ: begin
        w.horizontal_size = hdr[31:20];
        w.vertical_size   = hdr[19:8];
        w.aspect_code     = hdr[7:4];
        w.rate_code       = hdr[3:0];
        w.progressive_seq = pic_ext[0];
      end
      KIND_GOP: begin
        // Bit 31 is drop_frame and bit 19 a marker; neither is reported.
        hours      = hdr[30:26];
        minutes    = hdr[25:20];
        seconds    = hdr[18:13];
        frames     = hdr[12:7];
        w.gop_time = {hours, minutes, seconds, frames, hdr[6]};
      end
      default: begin
        w.temporal_ref   = hdr[31:22];
        w.coding_type    = hdr[21:19];
        w.picture_struct = pic_ext[4:3];
        w.picture_flags  = pic_ext[2:0];
      end
    endcase
    return w;
  endfunction

  // Extension tracking for one data byte of the open chunk; uses the byte history and
  // offset from before this byte.
  function automatic void ext_step(logic [7:0] b);
    logic [LEN_BITS-1:0] ext_floor;
    ext_floor = (cur_kind == KIND_SEQ) ? LEN_BITS'(7) : LEN_BITS'(5);
    case (ext_pos)
      EXT_ID: begin
        if ((cur_kind == KIND_SEQ && b[7:4] == EXT_ID_SEQ) ||
            (cur_kind == KIND_PIC && b[7:4] == EXT_ID_PIC)) begin
          ext_found = 1'b1;
          ext_pos   = EXT_B5;
        end else begin
          ext_pos = EXT_IDLE;
        end
      end
      EXT_B5: begin
        if (cur_kind == KIND_SEQ) begin
          pic_ext = {4'b0000, b[3]};
          ext_pos = EXT_IDLE;
        end else begin
          ext_pos = EXT_B6;
        end
      end
      EXT_B6: begin
        pic_ext[4:3] = b[1:0];
        ext_pos      = EXT_B7;
      end
      EXT_B7: begin
        pic_ext[2] = b[7];
        pic_ext[1] = b[1];
        ext_pos    = EXT_B8;
      end
      EXT_B8: begin
        pic_ext[0] = b[7];
        ext_pos    = EXT_IDLE;
      end
      default: begin
        ext_pos = EXT_IDLE;
        // Only the first extension counts, and only if its code starts late enough.
        if (!ext_found && cur_kind != KIND_GOP && last3 == START_PREFIX && b == SC_EXT &&
            offset >= LEN_BITS'(3) && offset - LEN_BITS'(3) >= ext_floor) begin
          ext_pos = EXT_ID;
        end
      end
    endcase
  endfunction

  // Advances the parser by one accepted byte and queues the chunk word it closes, if any.
  function automatic void parse_byte(in_t w);
    logic [7:0] b;
    bit eos, hit, closed;
    b      = w.data_byte;
    eos    = w.end_of_stream;
    closed = 1'b0;
    hit    = last3 == START_PREFIX && (b == SC_SEQ || b == SC_GOP || b == SC_PIC);
    // A code that began inside the first four bytes of the open chunk is plain data.
    if (hit && (!open_chunk || offset >= 7)) begin
      if (open_chunk) begin
        chunk_q.push_back(chunk_word((offset == OFFSET_SAT) ? OFFSET_SAT
                                                            : offset - LEN_BITS'(3)));
        closed = 1'b1;
      end
      // A code on the final byte closes the old chunk but opens none.
      open_chunk = !eos;
      cur_kind   = (b == SC_SEQ) ? KIND_SEQ : ((b == SC_GOP) ? KIND_GOP : KIND_PIC);
      offset     = LEN_BITS'(4);
      hdr        = '0;
      ext_pos    = EXT_IDLE;
      ext_found  = 1'b0;
      pic_ext    = (cur_kind == KIND_PIC) ? PIC_DEFAULTS : 5'b00000;
    end else if (open_chunk) begin
      if (offset >= 4 && offset <= 7) begin
        hdr[8 * (7 - offset[2:0]) +: 8] = b;
      end
      ext_step(b);
      if (offset != OFFSET_SAT) begin
        offset = offset + 1'b1;
      end
    end
    last3 = {last3[15:0], b};
    if (eos) begin
      if (open_chunk && !closed) begin
        chunk_q.push_back(chunk_word(offset));
      end
      parser_clear();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders.
  // ---------------------------------------------------------------------------
  function automatic void put(logic [7:0] b, bit eos = 1'b0);
    in_t w;
    w.data_byte     = b;
    w.end_of_stream = eos;
    stream_q.push_back(w);
  endfunction

  function automatic void put_code(logic [7:0] code, bit eos = 1'b0);
    put(8'h00);
    put(8'h00);
    put(8'h01);
    put(code, eos);
  endfunction

  function automatic void mark_last_eos();
    in_t w;
    w = stream_q.pop_back();
    w.end_of_stream = 1'b1;
    stream_q.push_back(w);
  endfunction

  // Appends an extension to a sequence or picture chunk. Returns 1 when the extension is
  // cut short, so that the caller ends the chunk right there.
  function automatic bit put_ext(logic [7:0] code);
    logic [3:0] id;
    int n;
    bit cut;
    if ($urandom_range(0, 4) == 0) begin
      id = 4'($urandom_range(0, 15));
    end else begin
      id = (code == SC_SEQ) ? EXT_ID_SEQ : EXT_ID_PIC;
    end
    put_code(SC_EXT);
    put({id, 4'($urandom_range(0, 15))});
    cut = $urandom_range(0, 3) == 0;
    n = cut ? $urandom_range(0, 3) : 4 + $urandom_range(0, 3);
    repeat (n) put(8'($urandom_range(0, 255)));
    return cut;
  endfunction

  // One chunk with random content: header, extensions and payload.
  function automatic void put_chunk();
    logic [7:0] code;
    int hlen;
    bit cut;
    case ($urandom_range(0, 2))
      0:       code = SC_SEQ;
      1:       code = SC_GOP;
      default: code = SC_PIC;
    endcase
    put_code(code);
    // Mostly complete headers; now and then a short one.
    if ($urandom_range(0, 4) == 0) begin
      hlen = $urandom_range(0, 4);
    end else begin
      hlen = 4 + ((code == SC_SEQ) ? $urandom_range(0, 4) : 0);
    end
    repeat (hlen) put(8'($urandom_range(0, 255)));
    cut = 1'b0;
    if (code != SC_GOP) begin
      repeat ($urandom_range(0, 2)) begin
        if (!cut) begin
          cut = put_ext(code);
        end
      end
    end
    if (!cut) begin
      repeat ($urandom_range(0, 10)) begin
        if ($urandom_range(0, 7) == 0) begin
          put(8'($urandom_range(0, 255)));
        end else begin
          put(8'($urandom_range(1, 255)));
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers one word per cycle from stream_q while in_ready takes them, with random
  // gaps outside a steady window. Every accepted word goes straight into the parser above.
  // ---------------------------------------------------------------------------
  int drv_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      parser_clear();
    end else begin
      drv_cycles++;
      if (in_valid && in_ready) begin
        parse_byte(in_data);
        bytes_taken++;
      end
      // The valid word stays put until taken; a new one may go out only once the slot frees.
      if (!in_valid || in_ready) begin
        if (stream_q.size() != 0 &&
            ((drv_cycles >= 700 && drv_cycles < 1100) || $urandom_range(0, 99) >= 24)) begin
          in_valid <= 1'b1;
          in_data  <= stream_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes chunk words with random stalls and checks each against the oldest
  // expected one. A long hold-off early in the run lets the result queue fill so that
  // the block has to stall its byte input.
  // ---------------------------------------------------------------------------
  int mon_cycles = 0;

  function automatic void field_diff(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fails++;
    end
  endfunction

  function automatic void check_chunk(out_t got);
    out_t want;
    if (chunk_q.size() == 0) begin
      $display("%0t ns: chunk word 0x%0h arrived with none expected", $time, got);
      fails++;
    end else begin
      want = chunk_q.pop_front();
      field_diff("chunk_kind",      want.chunk_kind,      got.chunk_kind);
      field_diff("chunk_length",    want.chunk_length,    got.chunk_length);
      field_diff("horizontal_size", want.horizontal_size, got.horizontal_size);
      field_diff("vertical_size",   want.vertical_size,   got.vertical_size);
      field_diff("aspect_code",     want.aspect_code,     got.aspect_code);
      field_diff("rate_code",       want.rate_code,       got.rate_code);
      field_diff("progressive_seq", want.progressive_seq, got.progressive_seq);
      field_diff("gop_time",        want.gop_time,        got.gop_time);
      field_diff("temporal_ref",    want.temporal_ref,    got.temporal_ref);
      field_diff("coding_type",     want.coding_type,     got.coding_type);
      field_diff("picture_struct",  want.picture_struct,  got.picture_struct);
      field_diff("picture_flags",   want.picture_flags,   got.picture_flags);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      mon_cycles++;
      if (out_valid && out_ready) begin
        check_chunk(out_data);
      end
      if (mon_cycles >= 300 && mon_cycles < 500) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= (mon_cycles >= 700 && mon_cycles < 1100) || $urandom_range(0, 99) >= 24;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int total;
    int pick;

    // Directed part. A final byte with no chunk open yields nothing.
    put(8'h00, 1'b1);
    // Sequence header with every header bit set.
    put_code(SC_SEQ);
    repeat (4) put(8'hFF);
    // GOP header with only one header byte; the next code's prefix fills the rest.
    put_code(SC_GOP);
    put(8'hFF);
    // Picture whose own code overlaps a sequence code: 00 00 01 00 00 01 B3 stays data.
    put_code(SC_PIC);
    put(8'h00);
    put(8'h01);
    put(SC_SEQ);
    put(8'hFF);
    // Picture extension that the next start code cuts off, where that code is also the
    // final byte of the stream.
    put_code(SC_EXT);
    put({EXT_ID_PIC, 4'hF});
    put(8'hFF);
    put_code(SC_GOP, 1'b1);

    // Random part: mostly well-formed chunks, with noise, broken codes and stream ends.
    while (stream_q.size() < 1030) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        put_chunk();
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
      end else if (pick < 91) begin
        put(8'h00);
        put(8'h00);
        if ($urandom_range(0, 1) == 1) begin
          put(8'h01);
        end
        put(8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
        mark_last_eos();
      end else begin
        put_code(($urandom_range(0, 1) == 1) ? SC_SEQ : SC_PIC, 1'b1);
      end
    end
    // The stream ends with a final byte so that the last chunk is flushed.
    mark_last_eos();
    total = stream_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < total) @(posedge clk);
    while (chunk_q.size() != 0) @(posedge clk);
    // Wait on so that any surplus chunk word still in the pipeline shows up.
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #200000;
    $display("FAIL");
    $finish;
  end

endmodule
